>>> hw/rtl/aat_pkg.sv
package aat_pkg;

  localparam int unsigned BarFullWidthDef = 95;
  localparam int unsigned AxisW = 17;
  localparam int unsigned MagW  = 18;
  localparam int unsigned SumW  = 36;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic [17:0] magnitude;
    logic        active;
    logic [15:0] seconds;
    logic [6:0]  bar_width;
    logic [1:0]  redraw;
    logic        expired;
  } out_t;

  typedef struct packed {
    logic [17:0] magnitude_threshold;
    logic [7:0]  window_length;
    logic [7:0]  hit_count_min;
    logic [7:0]  ticks_per_second;
    logic [15:0] limit_secs;
    logic [7:0]  idle_delay;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_WINDOW    = 3'd1,
    REG_HIT_MIN   = 3'd2,
    REG_TICKS     = 3'd3,
    REG_LIMIT     = 3'd4,
    REG_DELAY     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    REDRAW_NONE  = 2'd0,
    REDRAW_BAR   = 2'd1,
    REDRAW_RESET = 2'd2
  } redraw_e;

  localparam logic [13:0] FracWeight [10] = '{
    14'd5000, 14'd2500, 14'd1250, 14'd625, 14'd313,
    14'd156, 14'd78, 14'd39, 14'd20, 14'd10
  };

  // Convert one axis word into g*10000
  function automatic logic [AxisW-1:0] axis_value(logic [15:0] raw);
    logic [15:0]      w;
    logic [AxisW-1:0] v;
    w = raw[15] ? (16'd0 - raw) : raw;
    v = AxisW'(w[14:12]) * AxisW'(10000);
    for (int b = 0; b < 10; b++) begin
      if (w[11-b]) v = v + AxisW'(FracWeight[b]);
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/aat_front.sv
module aat_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aat_pkg::in_t         in_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [17:0]          mag_o
);
  import aat_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SQ   = 4'b0010,
    F_ROOT = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e          state_q, state_d;
  logic [AxisW-1:0] axis_q [3];
  logic [1:0]       sel_q;
  logic [SumW-1:0]  sum_q;
  logic [SumW-1:0]  rad_q;
  logic [20:0]      rem_q;
  logic [MagW-1:0]  root_q;
  logic [4:0]       cnt_q;
  logic [AxisW-1:0] axis_sel;
  logic [33:0]      prod;
  logic [SumW-1:0]  sum_d;
  logic [20:0]      rem_sh;
  logic [20:0]      trial;
  logic             take;

  assign in_ready_o = (state_q == F_IDLE);
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign mag_o      = root_q;

  // Shared squarer, one axis per cycle
  assign axis_sel = axis_q[sel_q];
  assign prod     = axis_sel * axis_sel;
  assign sum_d    = sum_q + SumW'(prod);

  // One root digit per cycle
  assign rem_sh = {rem_q[18:0], rad_q[SumW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (take) state_d = F_SQ;
      F_SQ:   if (sel_q == 2'd2) state_d = F_ROOT;
      F_ROOT: if (cnt_q == 5'd0) state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (take) begin
          axis_q[0] <= axis_value(in_data_i.accel_x);
          axis_q[1] <= axis_value(in_data_i.accel_y);
          axis_q[2] <= axis_value(in_data_i.accel_z);
          sum_q     <= '0;
          sel_q     <= 2'd0;
        end
      end
      F_SQ: begin
        sum_q <= sum_d;
        sel_q <= sel_q + 2'd1;
        if (sel_q == 2'd2) begin
          rad_q  <= sum_d;
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= 5'(MagW - 1);
        end
      end
      F_ROOT: begin
        rad_q <= rad_q << 2;
        cnt_q <= cnt_q - 5'd1;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[MagW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[MagW-2:0], 1'b0};
        end
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/aat_fifo.sv
module aat_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [17:0] data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [17:0] data_o
);
  logic [17:0] mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Store entry
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> hw/rtl/aat_back.sv
module aat_back #(
  parameter int unsigned BarFullWidth = aat_pkg::BarFullWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  aat_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  logic [17:0]   mag_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output aat_pkg::out_t out_data_o
);
  import aat_pkg::*;

  localparam int unsigned QW    = $clog2(BarFullWidth + 1);
  localparam int unsigned DW    = 16 + QW;
  localparam int unsigned StepW = (QW > 1) ? $clog2(QW) : 1;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_EMIT = 3'b100
  } bstate_e;

  bstate_e          state_q;
  logic [7:0]       pos_q, hit_q, tick_q;
  logic             active_q, exp_q;
  logic [15:0]      sec_q, idle_q;
  logic [6:0]       bar_q;
  logic [17:0]      mag_q;
  logic [1:0]       redraw_q;
  out_t             out_q;
  logic             out_valid_q;
  logic [DW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;
  logic [StepW-1:0] step_q;

  // Next-state values for one sample
  logic [7:0]  hit_n, pos_n, tick_n;
  logic [8:0]  pos_inc, tick_inc;
  logic        act_n, need_bar;
  logic [15:0] sec_n, idle_n;
  logic [16:0] idle_inc, idle_lim;
  logic [1:0]  redraw_n;
  logic [DW-1:0]  sub_val;
  logic           fits;
  logic [QW-1:0]  quo_d;

  assign pop_o       = (state_q == B_IDLE) && !empty_i && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idle_lim    = 17'(cfg_i.idle_delay) * 17'(cfg_i.ticks_per_second);

  always_comb begin
    hit_n    = hit_q;
    pos_n    = pos_q;
    tick_n   = tick_q;
    act_n    = active_q;
    sec_n    = sec_q;
    idle_n   = idle_q;
    redraw_n = REDRAW_NONE;
    need_bar = 1'b0;
    pos_inc  = 9'(pos_q) + 9'd1;
    tick_inc = 9'(tick_q) + 9'd1;
    idle_inc = 17'(idle_q) + 17'd1;
    // Count hits and close the window
    if (mag_i > cfg_i.magnitude_threshold && hit_q != 8'hFF) hit_n = hit_q + 8'd1;
    pos_n = pos_inc[7:0];
    if (pos_inc >= 9'(cfg_i.window_length)) begin
      if (hit_n > cfg_i.hit_count_min) begin
        act_n  = 1'b1;
        idle_n = '0;
      end
      if (hit_n == 8'd0) act_n = 1'b0;
      pos_n = '0;
      hit_n = '0;
    end
    // Advance seconds or idle time
    if (act_n) begin
      tick_n = tick_inc[7:0];
      if (tick_inc >= 9'(cfg_i.ticks_per_second)) begin
        tick_n   = '0;
        if (sec_q != 16'hFFFF) sec_n = sec_q + 16'd1;
        need_bar = 1'b1;
        redraw_n = REDRAW_BAR;
      end
    end else begin
      idle_n = idle_inc[15:0];
      if (idle_inc >= idle_lim) begin
        sec_n    = '0;
        idle_n   = '0;
        redraw_n = REDRAW_RESET;
      end
    end
  end

  // Restoring divide step
  assign sub_val = DW'(cfg_i.limit_secs) << step_q;
  assign fits    = rem_q >= sub_val;
  assign quo_d   = (quo_q << 1) | QW'(fits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pos_q       <= '0;
      hit_q       <= '0;
      tick_q      <= '0;
      active_q    <= 1'b0;
      exp_q       <= 1'b0;
      sec_q       <= '0;
      idle_q      <= '0;
      bar_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            state_q <= B_EMIT;
            if (!exp_q) begin
              pos_q    <= pos_n;
              hit_q    <= hit_n;
              tick_q   <= tick_n;
              active_q <= act_n;
              sec_q    <= sec_n;
              idle_q   <= idle_n;
              exp_q    <= (sec_n >= cfg_i.limit_secs);
              if (need_bar) begin
                if (cfg_i.limit_secs == 16'd0 || sec_n >= cfg_i.limit_secs) begin
                  bar_q <= 7'(BarFullWidth);
                end else begin
                  state_q <= B_DIV;
                end
              end
            end
          end
        end
        B_DIV: begin
          if (step_q == '0) begin
            bar_q   <= 7'(quo_d);
            state_q <= B_EMIT;
          end
        end
        B_EMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          mag_q    <= mag_i;
          redraw_q <= exp_q ? REDRAW_NONE : redraw_n;
          rem_q    <= DW'(sec_n) * DW'(BarFullWidth);
          quo_q    <= '0;
          step_q   <= StepW'(QW - 1);
        end
      end
      B_DIV: begin
        quo_q  <= quo_d;
        step_q <= step_q - StepW'(1);
        if (fits) rem_q <= rem_q - sub_val;
      end
      B_EMIT: begin
        out_q.magnitude <= mag_q;
        out_q.active    <= active_q;
        out_q.seconds   <= sec_q;
        out_q.bar_width <= bar_q;
        out_q.redraw    <= redraw_q;
        out_q.expired   <= exp_q;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/accel_activity_timer.sv
// Activity timer over three-axis accelerometer samples.
// Input channel in_valid_i/in_ready_o carries one sample (x, y, z words).
// Output channel out_valid_o/out_ready_i returns one result per sample:
// vector magnitude in g/10000, activity flag, active seconds, progress bar
// width, redraw code and expired flag.
// Configuration channel cfg_valid_i/cfg_ready_o writes one register per
// transfer; cfg_ready_o is always high. Write only while the block is idle.
// The front end takes one sample at a time: it squares the three axes on
// one shared multiplier, then computes 18 square root digits, and accepts
// no new sample until it has pushed the result. The back end computes
// one quotient bit per cycle for the bar division ($clog2(BarFullWidth+1),
// 7 at the default width) when a bar redraw needs it.
// A two-entry queue between front and back lets the front keep working
// while a result waits at the output; when the receiver stalls, the
// result holds steady and the queue fills, then in_ready_o drops.
// Reset clears all timer state and loads the default register values.
module accel_activity_timer #(
  parameter int unsigned BarFullWidth = aat_pkg::BarFullWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  aat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output aat_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [17:0]   cfg_data_i
);
  import aat_pkg::*;

  cfg_t        cfg_q;
  logic        push, full, pop, empty;
  logic [17:0] mag_front, mag_back;

  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magnitude_threshold <= 18'd20000;
      cfg_q.window_length       <= 8'd10;
      cfg_q.hit_count_min       <= 8'd2;
      cfg_q.ticks_per_second    <= 8'd15;
      cfg_q.limit_secs          <= 16'd30;
      cfg_q.idle_delay          <= 8'd5;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_THRESHOLD: cfg_q.magnitude_threshold <= cfg_data_i;
        REG_WINDOW:    cfg_q.window_length       <= cfg_data_i[7:0];
        REG_HIT_MIN:   cfg_q.hit_count_min       <= cfg_data_i[7:0];
        REG_TICKS:     cfg_q.ticks_per_second    <= cfg_data_i[7:0];
        REG_LIMIT:     cfg_q.limit_secs          <= cfg_data_i[15:0];
        REG_DELAY:     cfg_q.idle_delay          <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  aat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .mag_o      (mag_front)
  );

  aat_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (mag_front),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (mag_back)
  );

  aat_back #(
    .BarFullWidth (BarFullWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .mag_i       (mag_back),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/aat_checker.sv
module aat_checker #(
  parameter int unsigned BarFullWidth = aat_pkg::BarFullWidthDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input aat_pkg::out_t out_data_o
);
  import aat_pkg::*;

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Redraw code is one of the defined ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.redraw != 2'd3)
    else $error("bad redraw code");

  // Bar never exceeds the full width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bar_width <= 7'(BarFullWidth))
    else $error("bar too wide");

  // Green redraw comes with cleared seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.redraw == REDRAW_RESET |-> out_data_o.seconds == 16'd0)
    else $error("reset redraw with nonzero seconds");

endmodule

bind accel_activity_timer aat_checker #(
  .BarFullWidth (BarFullWidth)
) u_aat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> test/accel_activity_timer_test.sv
`timescale 1ns / 1ps

module accel_activity_timer_test;
  import aat_pkg::*;

  localparam int unsigned BarFull = 95;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;

  accel_activity_timer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Timer model state and register copy
  cfg_t regs;
  logic [7:0] win_pos, hits, tick_cnt;
  logic [15:0] secs, idle_cnt;
  logic [6:0] bar;
  logic act, done_flag;

  in_t sample_q[$];
  out_t result_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int red_cnt = 0;
  int green_cnt = 0;
  int exp_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic logic [16:0] axis_g(logic [15:0] raw);
    logic [15:0] w;
    logic [16:0] v;
    logic [13:0] wt [10];
    wt = '{5000, 2500, 1250, 625, 313, 156, 78, 39, 20, 10};
    w = raw[15] ? (16'd0 - raw) : raw;
    v = 17'(w[14:12]) * 17'd10000;
    for (int b = 0; b < 10; b++) begin
      if (w[11-b]) v = v + 17'(wt[b]);
    end
    return v;
  endfunction

  function automatic logic [17:0] floor_root(logic [35:0] v);
    logic [35:0] r;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      if (36'(r | (36'd1 << b)) * 36'(r | (36'd1 << b)) <= v) r = r | (36'd1 << b);
    end
    return r[17:0];
  endfunction

  function automatic out_t timer_step(in_t s);
    out_t o;
    logic [35:0] ax, ay, az;
    int unsigned w;
    redraw_e rd;
    ax = 36'(axis_g(s.accel_x));
    ay = 36'(axis_g(s.accel_y));
    az = 36'(axis_g(s.accel_z));
    o.magnitude = floor_root(ax * ax + ay * ay + az * az);
    rd = REDRAW_NONE;
    if (!done_flag) begin
      if (o.magnitude > regs.magnitude_threshold && hits < 8'd255) hits = hits + 1;
      win_pos = win_pos + 1;
      if (win_pos >= regs.window_length) begin
        if (hits > regs.hit_count_min) begin
          act = 1'b1;
          idle_cnt = '0;
        end
        if (hits == 0) act = 1'b0;
        win_pos = '0;
        hits = '0;
      end
      if (act) begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= regs.ticks_per_second) begin
          tick_cnt = '0;
          if (secs != 16'hFFFF) secs = secs + 1;
          if (regs.limit_secs == 0) w = BarFull;
          else w = (int'(secs) * BarFull) / int'(regs.limit_secs);
          if (w > BarFull) w = BarFull;
          bar = w[6:0];
          rd = REDRAW_BAR;
        end
      end else begin
        idle_cnt = idle_cnt + 1;
        if (32'(idle_cnt) >= 32'(regs.idle_delay) * 32'(regs.ticks_per_second)) begin
          secs = '0;
          idle_cnt = '0;
          rd = REDRAW_RESET;
        end
      end
      if (secs >= regs.limit_secs) done_flag = 1'b1;
    end
    o.active = act;
    o.seconds = secs;
    o.bar_width = bar;
    o.redraw = rd;
    o.expired = done_flag;
    return o;
  endfunction

  // Driver: offer queued samples, predict on each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(timer_step(in_data_i));
        sample_q.pop_front();
        sent++;
      end
      if ((!in_valid_i || in_ready_o) ) begin
        if (sample_q.size() > (in_valid_i && in_ready_o ? 0 : 0) && sample_q.size() > 0
            && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= sample_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down once per cycle
  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        received++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $realtime, out_data_o);
        end else begin
          out_t e;
          e = result_q.pop_front();
          if (e !== out_data_o) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data_o);
          end
          if (e.redraw == REDRAW_BAR) red_cnt++;
          if (e.redraw == REDRAW_RESET) green_cnt++;
          if (e.expired) exp_cnt++;
        end
      end
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [17:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_THRESHOLD: regs.magnitude_threshold = val;
      REG_WINDOW:    regs.window_length = val[7:0];
      REG_HIT_MIN:   regs.hit_count_min = val[7:0];
      REG_TICKS:     regs.ticks_per_second = val[7:0];
      REG_LIMIT:     regs.limit_secs = val[15:0];
      REG_DELAY:     regs.idle_delay = val[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Shaped sample: quiet, busy or fully random
  function automatic in_t make_sample(int busy_pct);
    in_t s;
    int m;
    m = $urandom_range(99);
    if (m < 10) begin
      s = {16'($urandom), 16'($urandom), 16'($urandom)};
    end else if (m < 10 + busy_pct) begin
      s.accel_x = 16'($urandom_range(12000) - 6000);
      s.accel_y = 16'($urandom_range(12000) - 6000);
      s.accel_z = 16'($urandom_range(12000) - 6000);
    end else begin
      s.accel_x = 16'($urandom_range(400) - 200);
      s.accel_y = 16'($urandom_range(400) - 200);
      s.accel_z = 16'(1024 + $urandom_range(200) - 100);
    end
    return s;
  endfunction

  task automatic run_phase(int n, int busy_pct);
    for (int i = 0; i < n; i++) sample_q.push_back(make_sample(busy_pct));
    wait_drained();
  endtask

  task automatic restore_defaults();
    write_reg(REG_THRESHOLD, 18'd20000);
    write_reg(REG_WINDOW, 18'd10);
    write_reg(REG_HIT_MIN, 18'd2);
    write_reg(REG_TICKS, 18'd15);
    write_reg(REG_LIMIT, 18'd30);
    write_reg(REG_DELAY, 18'd5);
  endtask

  initial begin
    regs = '{20000, 10, 2, 15, 30, 5};
    win_pos = '0; hits = '0; tick_cnt = '0; secs = '0; idle_cnt = '0;
    bar = '0; act = 1'b0; done_flag = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, most negative words, quiet and busy samples
    write_reg(REG_WINDOW, 18'd1);
    write_reg(REG_HIT_MIN, 18'd0);
    write_reg(REG_TICKS, 18'd1);
    write_reg(REG_LIMIT, 18'd200);
    write_reg(REG_DELAY, 18'd1);
    sample_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
    sample_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    sample_q.push_back('{16'sh8001, 16'sh7FFF, 16'sh8001});
    sample_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
    sample_q.push_back('{16'shFFFF, 16'sh0001, 16'sh5555});
    sample_q.push_back('{16'shAAAA, 16'sh5555, 16'sh0FFC});
    sample_q.push_back('{16'sh7FFF, 16'sh0000, 16'sh0000});
    sample_q.push_back('{16'sh7FFF, 16'sh8001, 16'sh0000});
    sample_q.push_back('{16'sh0000, 16'sh0000, 16'sh0004});
    sample_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
    wait_drained();

    // Register extremes
    write_reg(REG_THRESHOLD, 18'd0);
    write_reg(REG_WINDOW, 18'd255);
    write_reg(REG_HIT_MIN, 18'd255);
    write_reg(REG_TICKS, 18'd255);
    write_reg(REG_LIMIT, 18'hFFFF);
    write_reg(REG_DELAY, 18'd255);
    run_phase(20, 50);

    // Random phases under several register settings; once expired the
    // timer stays frozen and the predictor follows it.
    restore_defaults();
    run_phase(250, 60);
    send_idle_pct = 57;
    write_reg(REG_THRESHOLD, 18'd12000);
    write_reg(REG_WINDOW, 18'd4);
    write_reg(REG_TICKS, 18'd3);
    write_reg(REG_LIMIT, 18'd1000);
    run_phase(300, 40);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_phase(300, 70);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    hold_off = 300;
    run_phase(300, 50);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_WINDOW, 18'd1);
    write_reg(REG_TICKS, 18'd1);
    write_reg(REG_DELAY, 18'd2);
    write_reg(REG_LIMIT, 18'd40);
    run_phase(400, 50);
    recv_stall_pct = 57;
    run_phase(200, 50);

    // Zero limit expires at once and freezes the timer; only reset leaves it
    recv_stall_pct = 0;
    write_reg(REG_THRESHOLD, 18'h3FFFF);
    write_reg(REG_LIMIT, 18'd0);
    sample_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    sample_q.push_back('{16'sh1234, 16'shC000, 16'sh0400});
    wait_drained();

    $display("Covered %0d samples, %0d results: %0d bar redraws, %0d reset redraws,",
             sent, received, red_cnt, green_cnt);
    $display("%0d results with the expired flag set, under several register settings.",
             exp_cnt);
    if (errors == 0) begin
      $display("accel_activity_timer_test: clean");
    end else begin
      $display("accel_activity_timer_test: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("accel_activity_timer_test: errors");
    $finish;
  end

endmodule
